### src/b64sd_pkg.sv
package b64sd_pkg;

    localparam int QDepth    = 4;
    localparam int QPtrWidth = $clog2(QDepth);
    localparam int QCntWidth = $clog2(QDepth + 1);

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_LENGTH     = 3'd1,
        ST_BAD_PAD        = 3'd2,
        ST_DATA_AFTER_PAD = 3'd3,
        ST_BAD_CHAR       = 3'd4,
        ST_PAD_NOT_FINAL  = 3'd5
    } status_t;

    // One queue entry: the bytes of a finished group and/or the closing status.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        has_status;
        status_t     status;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_flags_t;

    localparam logic [7:0] CharPad   = 8'h3D;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharSlash = 8'h2F;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    // Bit 6 set marks a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c inside {[8'h41:8'h5A]})
        begin
            v = 7'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            v = 7'(c - 8'd71);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            v = 7'(c + 8'd4);
        end
        else if (c == CharPlus)
        begin
            v = 7'd62;
        end
        else if (c == CharSlash)
        begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

### src/b64sd_front.sv
module b64sd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         text_char,
    input  logic               end_of_text,
    input  b64sd_pkg::q_flags_t q_flags,
    output logic               push,
    output b64sd_pkg::q_entry_t push_entry
);
    import b64sd_pkg::*;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        pgs_reg, pgs_next;
    status_t     err_reg, err_next;

    logic        accept;
    logic        blank;
    logic [6:0]  sx;
    logic [5:0]  v;
    logic [1:0]  nb;
    logic [23:0] word;
    status_t     st;

    assign in_ready = !q_flags.full;
    assign accept   = in_valid && in_ready;
    assign blank    = is_blank(text_char);
    assign sx       = sextet_of(text_char);

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        pad_next = pad_reg;
        pgs_next = pgs_reg;
        err_next = err_reg;
        v        = 6'd0;
        nb       = 2'd0;
        word     = {acc_reg, 6'd0};
        st       = ST_OK;
        if (!blank)
        begin
            if (pgs_reg && err_next == ST_OK)
                err_next = ST_PAD_NOT_FINAL;
            if (text_char == CharPad)
            begin
                if (pos_reg < 2'd2 && err_next == ST_OK)
                    err_next = ST_BAD_PAD;
                pad_next = pad_reg + 2'd1;
            end
            else
            begin
                if (pad_reg != 2'd0 && err_next == ST_OK)
                    err_next = ST_DATA_AFTER_PAD;
                if (sx[6])
                begin
                    if (err_next == ST_OK)
                        err_next = ST_BAD_CHAR;
                end
                else
                begin
                    v = sx[5:0];
                end
            end
            word = {acc_reg, v};
            if (pos_reg == 2'd3)
            begin
                if (err_next == ST_OK)
                begin
                    if (pad_next == 2'd0)
                        nb = 2'd3;
                    else if (pad_next == 2'd1)
                        nb = 2'd2;
                    else
                        nb = 2'd1;
                end
                if (pad_next != 2'd0)
                    pgs_next = 1'b1;
                acc_next = '0;
                pad_next = 2'd0;
            end
            else if (pos_reg == 2'd0)
            begin
                acc_next = {12'd0, v};
            end
            else
            begin
                acc_next = {acc_reg[11:0], v};
            end
            pos_next = pos_reg + 2'd1;
        end
        if (end_of_text)
        begin
            st       = (pos_next != 2'd0) ? ST_BAD_LENGTH : err_next;
            acc_next = '0;
            pos_next = 2'd0;
            pad_next = 2'd0;
            pgs_next = 1'b0;
            err_next = ST_OK;
        end
    end

    assign push                  = accept && (nb != 2'd0 || end_of_text);
    assign push_entry.word       = word;
    assign push_entry.nbytes     = nb;
    assign push_entry.has_status = end_of_text;
    assign push_entry.status     = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            pad_reg <= '0;
            pgs_reg <= 1'b0;
            err_reg <= ST_OK;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            pgs_reg <= pgs_next;
            err_reg <= err_next;
        end
    end

endmodule

### src/b64sd_queue.sv
module b64sd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64sd_pkg::q_entry_t push_entry,
    input  logic                pop,
    output b64sd_pkg::q_entry_t head,
    output b64sd_pkg::q_flags_t flags
);
    import b64sd_pkg::*;

    q_entry_t               mem_reg [QDepth];
    logic [QPtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCntWidth-1:0]   cnt_reg, cnt_next;

    assign head        = mem_reg[rd_ptr_reg];
    assign flags.empty = (cnt_reg == '0);
    assign flags.full  = (cnt_reg == QCntWidth'(QDepth));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPtrWidth'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPtrWidth'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCntWidth'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCntWidth'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/b64sd_back.sv
module b64sd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64sd_pkg::q_entry_t head,
    input  b64sd_pkg::q_flags_t q_flags,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          data_byte,
    output logic                byte_valid,
    output logic [2:0]          status,
    output logic                last
);
    import b64sd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       bv_reg;
    status_t    st_reg;
    logic       last_reg;

    logic       load;
    logic [2:0] total;
    logic       entry_done;
    logic       is_byte;
    logic [7:0] sel_byte;

    assign load       = !q_flags.empty && (!valid_reg || out_ready);
    assign total      = {1'b0, head.nbytes} + {2'b00, head.has_status};
    assign entry_done = ({1'b0, idx_reg} == total - 3'd1);
    assign is_byte    = (idx_reg < head.nbytes);
    assign pop        = load && entry_done;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.word[23:16];
            2'd1:    sel_byte = head.word[15:8];
            default: sel_byte = head.word[7:0];
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = entry_done ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= is_byte ? sel_byte : 8'd0;
            bv_reg   <= is_byte;
            st_reg   <= is_byte ? ST_OK : head.status;
            last_reg <= !is_byte;
        end
    end

    assign out_valid  = valid_reg;
    assign data_byte  = byte_reg;
    assign byte_valid = bv_reg;
    assign status     = st_reg;
    assign last       = last_reg;

endmodule

### src/base64_stream_decoder_unit.sv
// A result is written into the queue when the character that completes its
// group (or carries the end mark) is accepted, then registered by the back end.
// Throughput: one character and, while m_tready is high, one result per cycle.
// A four-entry queue between the classifier and the result serializer absorbs
// the up-to-four results one character can cause; input stalls only when full.
// Reset: rst_n is asynchronous, active low, and clears decoder state and queue.
module base64_stream_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [3:0] m_tuser,   // [0] byte_valid, [3:1] status
    output logic       m_tlast    // last
);
    import b64sd_pkg::*;

    q_flags_t q_flags;
    q_entry_t push_entry;
    q_entry_t head;
    logic     push;
    logic     pop;
    logic     byte_valid;
    logic [2:0] status;

    b64sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .text_char  (s_tdata),
        .end_of_text(s_tlast),
        .q_flags    (q_flags),
        .push       (push),
        .push_entry (push_entry)
    );

    b64sd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .flags     (q_flags)
    );

    b64sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_flags   (q_flags),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .data_byte (m_tdata),
        .byte_valid(byte_valid),
        .status    (status),
        .last      (m_tlast)
    );

    assign m_tuser = {status, byte_valid};

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_flags.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!q_flags.empty))
        else $error("queue read while empty");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == !byte_valid))
        else $error("last flag and byte flag disagree");

    a_byte_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && byte_valid) |-> (status == ST_OK))
        else $error("byte result carries nonzero status");

    a_status_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !byte_valid) |-> (m_tdata == 8'd0))
        else $error("status result carries data");
`endif

endmodule
